// File: rtl/qro_pkg.sv
`timescale 1ns / 1ps

package qro_pkg;

   localparam int unsigned NORM_PERIOD_DEFAULT = 256;

   localparam int unsigned PHASOR_W = 32;
   localparam int unsigned GAIN_W   = 20;
   localparam int unsigned OFFSET_W = 21;
   localparam int unsigned SAMPLE_W = 22;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned ADDR_W   = 4;

   // multiplier: 32-bit phasor times 33-bit operand, product and running sum
   localparam int unsigned MUL_B_W = 33;
   localparam int unsigned PROD_W  = 65;
   localparam int unsigned SUM_W   = 66;

   localparam logic signed [PHASOR_W-1:0] STEP_SINE_RESET   = 32'sd331804471;
   localparam logic signed [PHASOR_W-1:0] STEP_COSINE_RESET = 32'sd1021189158;
   localparam logic [GAIN_W-1:0]          GAIN_RESET        = 20'd65536;
   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET      = 21'sd0;
   localparam logic signed [PHASOR_W-1:0] ONE_Q30           = 32'sd1073741824;

   localparam logic signed [SUM_W-1:0] OUT_LIMIT   = 66'sd1310720;
   localparam logic signed [SUM_W-1:0] K_LIMIT     = 66'sd4294967295;
   localparam logic signed [SUM_W-1:0] THREE_Q30   = 66'sd3221225472;
   localparam logic signed [SUM_W-1:0] SAT32_HIGH  = 66'sd2147483647;
   localparam logic signed [SUM_W-1:0] SAT32_LOW   = -66'sd2147483648;

   typedef enum logic [1:0] {
      REG_STEP_SINE   = 2'd0,
      REG_STEP_COSINE = 2'd1,
      REG_GAIN        = 2'd2,
      REG_OFFSET      = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OUT_SINE,
      ST_OUT_COS,
      ST_ROT_S1,
      ST_ROT_S2,
      ST_ROT_C1,
      ST_ROT_C2,
      ST_ROT_END,
      ST_NORM_1,
      ST_NORM_2,
      ST_NORM_K,
      ST_NORM_S,
      ST_NORM_C,
      ST_NORM_END,
      ST_DONE
   } state_type;

endpackage

// File: rtl/quadrature_rotation_oscillator.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports
// ------    ---------  ----------------------------------------------------
// req       in         req_valid, req_ready, req_tick
// rsp       out        rsp_valid, rsp_ready, rsp_sine_sample, rsp_cosine_sample
// csr       in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// For a word with tick high the block runs the output, rotation and, on a
// renormalization tick, normalization steps, registers the result and goes idle.
// All products go through one shared 32x33 multiplier, one product per cycle.
// A word with tick low is accepted and gives no result.
// Reset is synchronous; it restores the registers and the unit phasor.
// A finished result waits while the output register is full, holding req_ready low.
module quadrature_rotation_oscillator #(
   parameter int unsigned NORM_PERIOD = qro_pkg::NORM_PERIOD_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_tick,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [qro_pkg::SAMPLE_W-1:0] rsp_sine_sample,
   output logic signed [qro_pkg::SAMPLE_W-1:0] rsp_cosine_sample,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [qro_pkg::ADDR_W-1:0]          paddr,
   input  logic [qro_pkg::CSR_W-1:0]           pwdata,
   output logic [qro_pkg::CSR_W-1:0]           prdata,
   output logic                                pready
);

   import qro_pkg::*;

   localparam int unsigned COUNT_W = (NORM_PERIOD > 1) ? $clog2(NORM_PERIOD) : 1;
   localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(NORM_PERIOD - 1);

   function automatic logic signed [SUM_W-1:0] rshr_f(
      input logic signed [SUM_W-1:0] x,
      input int unsigned             n
   );
      logic signed [SUM_W-1:0] half;
      half = SUM_W'(1) <<< (n - 1);
      return (x + half) >>> n;
   endfunction

   function automatic logic signed [SUM_W-1:0] clamp_f(
      input logic signed [SUM_W-1:0] x,
      input logic signed [SUM_W-1:0] lo,
      input logic signed [SUM_W-1:0] hi
   );
      logic signed [SUM_W-1:0] r;
      r = x;
      if (x < lo) begin
         r = lo;
      end else if (x > hi) begin
         r = hi;
      end
      return r;
   endfunction

   // configuration
   logic signed [PHASOR_W-1:0] step_sine_ff;
   logic signed [PHASOR_W-1:0] step_cosine_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic signed [OFFSET_W-1:0] offset_ff;
   logic                       csr_write;
   reg_index_type              csr_index;

   // oscillator state and datapath
   state_type                  state_ff, state_in;
   logic signed [PHASOR_W-1:0] phasor_sine_ff;
   logic signed [PHASOR_W-1:0] phasor_cosine_ff;
   logic signed [PHASOR_W-1:0] new_sine_ff;
   logic [COUNT_W-1:0]         tick_count_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W-1:0]   acc_ff;
   logic signed [MUL_B_W-1:0]  k_ff;
   logic signed [SAMPLE_W-1:0] sine_hold_ff, cos_hold_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sine_ff, rsp_cos_ff;

   // sequencer controls
   logic signed [PHASOR_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic                       sum_sub;
   logic                       count_wrap;
   logic                       out_free;

   // derived values
   logic signed [SUM_W-1:0]    prod_ext, acc_ext, sum_w;
   logic signed [SUM_W-1:0]    sample_w;
   logic signed [SUM_W-1:0]    rot_w;
   logic signed [SUM_W-1:0]    k_w;
   logic signed [SUM_W-1:0]    norm_w;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_sine_ff   <= STEP_SINE_RESET;
         step_cosine_ff <= STEP_COSINE_RESET;
         gain_ff        <= GAIN_RESET;
         offset_ff      <= OFFSET_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_STEP_SINE:   step_sine_ff   <= signed'(pwdata);
            REG_STEP_COSINE: step_cosine_ff <= signed'(pwdata);
            REG_GAIN:        gain_ff        <= pwdata[GAIN_W-1:0];
            REG_OFFSET:      offset_ff      <= signed'(pwdata[OFFSET_W-1:0]);
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_STEP_SINE:   prdata = step_sine_ff;
         REG_STEP_COSINE: prdata = step_cosine_ff;
         REG_GAIN:        prdata = CSR_W'(gain_ff);
         REG_OFFSET:      prdata = CSR_W'(signed'(offset_ff));
         default:         prdata = '0;
      endcase
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign count_wrap = (tick_count_ff == COUNT_LAST);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_tick) begin
               state_in = ST_OUT_SINE;
            end
         end
         ST_OUT_SINE: state_in = ST_OUT_COS;
         ST_OUT_COS:  state_in = ST_ROT_S1;
         ST_ROT_S1:   state_in = ST_ROT_S2;
         ST_ROT_S2:   state_in = ST_ROT_C1;
         ST_ROT_C1:   state_in = ST_ROT_C2;
         ST_ROT_C2:   state_in = ST_ROT_END;
         ST_ROT_END:  state_in = count_wrap ? ST_NORM_1 : ST_DONE;
         ST_NORM_1:   state_in = ST_NORM_2;
         ST_NORM_2:   state_in = ST_NORM_K;
         ST_NORM_K:   state_in = ST_NORM_S;
         ST_NORM_S:   state_in = ST_NORM_C;
         ST_NORM_C:   state_in = ST_NORM_END;
         ST_NORM_END: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // multiplier operands for each step
   always_comb begin
      mul_a   = phasor_sine_ff;
      mul_b   = '0;
      sum_sub = 1'b0;
      unique case (state_ff)
         ST_OUT_SINE: begin
            mul_a = phasor_sine_ff;
            mul_b = signed'(MUL_B_W'(gain_ff));
         end
         ST_OUT_COS: begin
            mul_a = phasor_cosine_ff;
            mul_b = signed'(MUL_B_W'(gain_ff));
         end
         ST_ROT_S1: begin
            mul_a = phasor_sine_ff;
            mul_b = MUL_B_W'(step_cosine_ff);
         end
         ST_ROT_S2: begin
            mul_a = phasor_cosine_ff;
            mul_b = MUL_B_W'(step_sine_ff);
         end
         ST_ROT_C1: begin
            mul_a = phasor_cosine_ff;
            mul_b = MUL_B_W'(step_cosine_ff);
         end
         ST_ROT_C2: begin
            mul_a = phasor_sine_ff;
            mul_b = MUL_B_W'(step_sine_ff);
         end
         ST_ROT_END: begin
            sum_sub = 1'b1;
         end
         ST_NORM_1: begin
            mul_a = phasor_sine_ff;
            mul_b = MUL_B_W'(phasor_sine_ff);
         end
         ST_NORM_2: begin
            mul_a = phasor_cosine_ff;
            mul_b = MUL_B_W'(phasor_cosine_ff);
         end
         ST_NORM_S: begin
            mul_a = phasor_sine_ff;
            mul_b = k_ff;
         end
         ST_NORM_C: begin
            mul_a = phasor_cosine_ff;
            mul_b = k_ff;
         end
         default: ;
      endcase
   end

   assign prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_ext = SUM_W'(prod_ff);
   assign acc_ext  = SUM_W'(acc_ff);
   assign sum_w    = sum_sub ? (acc_ext - prod_ext) : (acc_ext + prod_ext);

   assign sample_w = clamp_f(rshr_f(prod_ext, 30) + SUM_W'(offset_ff), -OUT_LIMIT, OUT_LIMIT);
   assign rot_w    = clamp_f(rshr_f(sum_w, 30), SAT32_LOW, SAT32_HIGH);
   assign k_w      = clamp_f(THREE_Q30 - rshr_f(sum_w, 30), -K_LIMIT, K_LIMIT);
   assign norm_w   = clamp_f(rshr_f(prod_ext, 31), SAT32_LOW, SAT32_HIGH);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (state_ff)
         ST_OUT_COS:  sine_hold_ff <= sample_w[SAMPLE_W-1:0];
         ST_ROT_S1:   cos_hold_ff  <= sample_w[SAMPLE_W-1:0];
         ST_ROT_S2,
         ST_ROT_C2,
         ST_NORM_2:   acc_ff       <= prod_ff;
         ST_ROT_C1:   new_sine_ff  <= rot_w[PHASOR_W-1:0];
         ST_NORM_K:   k_ff         <= k_w[MUL_B_W-1:0];
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         phasor_sine_ff   <= '0;
         phasor_cosine_ff <= ONE_Q30;
         tick_count_ff    <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_ROT_END: begin
               // commit the rotation, then advance the renormalization count
               phasor_sine_ff   <= new_sine_ff;
               phasor_cosine_ff <= rot_w[PHASOR_W-1:0];
               tick_count_ff    <= count_wrap ? '0 : tick_count_ff + 1'b1;
            end
            ST_NORM_C:   phasor_sine_ff   <= norm_w[PHASOR_W-1:0];
            ST_NORM_END: phasor_cosine_ff <= norm_w[PHASOR_W-1:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_sine_ff <= sine_hold_ff;
         rsp_cos_ff  <= cos_hold_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sine_sample   = rsp_sine_ff;
   assign rsp_cosine_sample = rsp_cos_ff;

endmodule

// File: sim/quadrature_rotation_oscillator_tb.sv
`timescale 1ns / 1ps

module quadrature_rotation_oscillator_tb;
   import qro_pkg::*;

   localparam int unsigned NORM_PERIOD = NORM_PERIOD_DEFAULT;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 24;
   localparam int RANDOM_PHASES   = 12;
   localparam int TICKS_PER_PHASE = 118;
   localparam int REPORT_LIMIT    = 10;

   typedef logic signed [127:0] wide_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef struct packed {
      sample_type sine;
      sample_type cosine;
   } sample_pair_type;

   class osc_scoreboard_type;
      logic signed [PHASOR_W-1:0] step_sin;
      logic signed [PHASOR_W-1:0] step_cos;
      logic [GAIN_W-1:0]          gain;
      logic signed [OFFSET_W-1:0] offset;
      logic signed [PHASOR_W-1:0] ph_sin;
      logic signed [PHASOR_W-1:0] ph_cos;
      int unsigned                tick_count;
      sample_pair_type            expected_samples[$];
      int mismatches;
      int unexpected;
      int checked;
      int renorms;
      int clipped;

      function new();
         step_sin   = STEP_SINE_RESET;
         step_cos   = STEP_COSINE_RESET;
         gain       = GAIN_RESET;
         offset     = OFFSET_RESET;
         ph_sin     = '0;
         ph_cos     = ONE_Q30;
         tick_count = 0;
         mismatches = 0;
         unexpected = 0;
         checked    = 0;
         renorms    = 0;
         clipped    = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_W-1:0] value);
         case (idx)
            REG_STEP_SINE:   step_sin = value;
            REG_STEP_COSINE: step_cos = value;
            REG_GAIN:        gain = value[GAIN_W-1:0];
            REG_OFFSET:      offset = value[OFFSET_W-1:0];
            default: ;
         endcase
      endfunction

      // round to nearest, ties toward plus infinity
      function wide_type round_shift(wide_type x, int unsigned n);
         return (x + (wide_type'(1) <<< (n - 1))) >>> n;
      endfunction

      function logic signed [PHASOR_W-1:0] sat32(wide_type x);
         wide_type hi;
         wide_type lo;
         hi = (wide_type'(1) <<< 31) - 1;
         lo = -(wide_type'(1) <<< 31);
         if (x > hi) return hi[PHASOR_W-1:0];
         if (x < lo) return lo[PHASOR_W-1:0];
         return x[PHASOR_W-1:0];
      endfunction

      function sample_type scale_sample(logic signed [PHASOR_W-1:0] unit);
         wide_type v;
         wide_type lim;
         lim = 1310720;
         v = round_shift(wide_type'(unit) * wide_type'({1'b0, gain}), 30) + wide_type'(offset);
         if (v > lim) begin
            v = lim;
            clipped++;
         end else if (v < -lim) begin
            v = -lim;
            clipped++;
         end
         return v[SAMPLE_W-1:0];
      endfunction

      function void note_word(bit tick);
         wide_type s;
         wide_type c;
         wide_type sn;
         wide_type cs;
         wide_type m;
         wide_type k;
         wide_type klim;
         sample_pair_type pair;
         if (!tick) return;
         s  = wide_type'(ph_sin);
         c  = wide_type'(ph_cos);
         sn = wide_type'(step_sin);
         cs = wide_type'(step_cos);
         // emit from the phasor before it moves
         pair.sine   = scale_sample(ph_sin);
         pair.cosine = scale_sample(ph_cos);
         expected_samples.push_back(pair);
         ph_sin = sat32(round_shift(s * cs + c * sn, 30));
         ph_cos = sat32(round_shift(c * cs - s * sn, 30));
         tick_count++;
         if (tick_count >= NORM_PERIOD) begin
            tick_count = 0;
            renorms++;
            s    = wide_type'(ph_sin);
            c    = wide_type'(ph_cos);
            m    = round_shift(s * s + c * c, 30);
            klim = (wide_type'(1) <<< 32) - 1;
            k    = (wide_type'(3) <<< 30) - m;
            if (k > klim) k = klim;
            else if (k < -klim) k = -klim;
            ph_sin = sat32(round_shift(s * k, 31));
            ph_cos = sat32(round_shift(c * k, 31));
         end
      endfunction

      function void check_result(sample_type sine, sample_type cosine);
         sample_pair_type want;
         if (expected_samples.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= REPORT_LIMIT)
               $display("ERROR: unexpected word: sine %0d cosine %0d", sine, cosine);
            return;
         end
         want = expected_samples.pop_front();
         checked++;
         if (want.sine !== sine || want.cosine !== cosine) begin
            mismatches++;
            if (mismatches + unexpected <= REPORT_LIMIT)
               $display("ERROR: word %0d: sine exp %0d got %0d, cosine exp %0d got %0d",
                        checked, want.sine, sine, want.cosine, cosine);
         end
      endfunction
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_tick  = 1'b0;
   logic                 rsp_ready = 1'b0;
   logic                 psel      = 1'b0;
   logic                 penable   = 1'b0;
   logic                 pwrite    = 1'b0;
   logic [ADDR_W-1:0]    paddr     = '0;
   logic [CSR_W-1:0]     pwdata    = '0;
   logic                 req_ready;
   logic                 rsp_valid;
   sample_type           rsp_sine_sample;
   sample_type           rsp_cosine_sample;
   logic [CSR_W-1:0]     prdata;
   logic                 pready;

   osc_scoreboard_type board;
   int send_idle_pct   = 15;
   int recv_idle_pct   = 69;
   int holds_requested = 0;
   int holds_served    = 0;
   int hold_left       = 0;
   int stall_cycles    = 0;
   int words_sent      = 0;
   int ticks_sent      = 0;
   int regs_written    = 0;

   quadrature_rotation_oscillator #(
      .NORM_PERIOD(NORM_PERIOD)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_tick(req_tick),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sine_sample(rsp_sine_sample),
      .rsp_cosine_sample(rsp_cosine_sample),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, plus a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_requested) begin
         rsp_ready    <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_sine_sample, rsp_cosine_sample);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // offer one word and hold it until accepted
   task automatic send_word(bit tick);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick  <= tick;
      do @(posedge clock); while (!req_ready);
      board.note_word(tick);
      words_sent++;
      if (tick) ticks_sent++;
   endtask

   task automatic run_ticks(int count);
      int done;
      bit tick;
      done = 0;
      while (done < count) begin
         tick = ($urandom_range(99) >= 12);
         send_word(tick);
         if (tick) done++;
      end
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.write_reg(idx, value);
      regs_written++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // drain all results, let the datapath go quiet, then reprogram
   task automatic configure(logic [CSR_W-1:0] sn, logic [CSR_W-1:0] cs,
                            logic [CSR_W-1:0] g, logic [CSR_W-1:0] o);
      req_valid <= 1'b0;
      while (board.expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_STEP_SINE, sn);
      csr_write(REG_STEP_COSINE, cs);
      csr_write(REG_GAIN, g);
      csr_write(REG_OFFSET, o);
   endtask

   task automatic configure_random(int phase);
      real theta;
      logic [CSR_W-1:0] sn_w;
      logic [CSR_W-1:0] cs_w;
      logic [CSR_W-1:0] g_w;
      logic [CSR_W-1:0] o_w;
      int gain_val;
      int offset_val;
      theta = real'($urandom_range(0, 62831)) / 10000.0 - 3.14159;
      sn_w  = int'($sin(theta) * 1073741824.0);
      cs_w  = int'($cos(theta) * 1073741824.0);
      case (phase)
         0: begin gain_val = 0; offset_val = $urandom_range(0, 1310720) - 655360; end
         1: begin gain_val = 655360; offset_val = 655360; end
         2: begin gain_val = 655360; offset_val = -655360; end
         3: begin gain_val = 20'hFFFFF; offset_val = 655360; end
         default: begin
            gain_val   = $urandom_range(0, 655360);
            offset_val = $urandom_range(0, 1310720) - 655360;
         end
      endcase
      // random upper bits; the register keeps only its own width
      g_w = ($urandom & 32'hFFF0_0000) | gain_val;
      o_w = offset_val;
      if ($urandom_range(3) == 0) o_w = $urandom;
      configure(sn_w, cs_w, g_w, o_w);
   endtask

   initial begin
      int phase;
      int failures;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, with idle ticks mixed in
      send_word(1'b0);
      send_word(1'b1);
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b0);
      send_word(1'b1);
      send_word(1'b1);
      // quarter-turn step, largest gain pattern, offset at both field extremes
      configure(32'h4000_0000, 32'h0000_0000, 32'hABCF_FFFF, 32'h000F_FFFF);
      repeat (4) send_word(1'b1);
      configure(32'h4000_0000, 32'h0000_0000, 32'h000F_FFFF, 32'hFFF0_0000);
      repeat (4) send_word(1'b1);
      // zero gain leaves only the offset, then a large gain with a negative offset
      configure(STEP_SINE_RESET, STEP_COSINE_RESET, 32'h0, 32'd655360);
      repeat (2) send_word(1'b1);
      configure(STEP_SINE_RESET, STEP_COSINE_RESET, 32'd655360, 32'hFFF6_0000);
      repeat (2) send_word(1'b1);
      // half-turn step
      configure(32'h0000_0000, 32'hC000_0000, 32'd65536, 32'h0);
      repeat (2) send_word(1'b1);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES / 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 15;
         end else if (phase == 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure_random(phase);
         if (phase == 5) begin
            run_ticks(TICKS_PER_PHASE / 2);
            holds_requested++;
            run_ticks(TICKS_PER_PHASE - TICKS_PER_PHASE / 2);
         end else if (phase == 9) begin
            run_ticks(TICKS_PER_PHASE / 2);
            // pause the sender until everything has come back
            req_valid <= 1'b0;
            do @(posedge clock); while (board.expected_samples.size() != 0);
            run_ticks(TICKS_PER_PHASE - TICKS_PER_PHASE / 2);
         end else begin
            run_ticks(TICKS_PER_PHASE);
         end
      end

      // oversized step: saturate the phasor and carry it through a renormalization
      configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd655360, 32'h0);
      run_ticks(NORM_PERIOD - board.tick_count + 4);
      // shrink back toward unit magnitude
      configure(32'h1000_0000, 32'h2000_0000, 32'd65536, 32'h0);
      run_ticks(2);
      configure_random(RANDOM_PHASES);
      run_ticks(60);

      req_valid <= 1'b0;
      do @(posedge clock); while (board.expected_samples.size() != 0);
      repeat (30) @(posedge clock);

      failures = board.mismatches + board.unexpected + board.expected_samples.size();
      $display("run: %0d words (%0d ticks), %0d results checked, %0d register writes",
               words_sent, ticks_sent, board.checked, regs_written);
      $display("run: %0d renormalizations, %0d clipped samples, %0d failures",
               board.renorms, board.clipped, failures);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
